// File: hdl/jhsl_pkg.sv
`timescale 1ns / 1ps

package jhsl_pkg;

	localparam int COUNT_BITS = 24;
	localparam int FIELD_BITS = 24;
	localparam logic [32:0] FIELD_MAX = 33'h0_00FF_FFFF;

	localparam logic [7:0] MK_PREFIX = 8'hFF;
	localparam logic [7:0] MK_SOI    = 8'hD8;
	localparam logic [7:0] MK_APP0   = 8'hE0;
	localparam logic [7:0] MK_DQT    = 8'hDB;
	localparam logic [7:0] MK_SOF0   = 8'hC0;
	localparam logic [7:0] MK_DHT    = 8'hC4;
	localparam logic [7:0] MK_SOS    = 8'hDA;

	typedef enum logic [3:0] {
		PH_SOI0 = 4'd0,
		PH_SOI1 = 4'd1,
		PH_MK0  = 4'd2,
		PH_MK1  = 4'd3,
		PH_LENH = 4'd4,
		PH_LENL = 4'd5,
		PH_BODY = 4'd6,
		PH_SCAN = 4'd7,
		PH_HALT = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_APP0 = 3'd1,
		KIND_DQT  = 3'd2,
		KIND_SOF  = 3'd3,
		KIND_DHT  = 3'd4,
		KIND_SOS  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ORDER = 2'd1,
		ST_TRUNC = 2'd2,
		ST_LEN   = 2'd3
	} status_t;

	typedef struct packed {
		status_t               status;
		logic [FIELD_BITS-1:0] scan_offset;
		logic [FIELD_BITS-1:0] scan_length;
		logic [15:0]           frame_width;
		logic [15:0]           frame_height;
	} result_t;

	// clamp a count (up to COUNT_BITS+1 bits) to the 24-bit result range
	function automatic logic [FIELD_BITS-1:0] sat_field(input logic [COUNT_BITS:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > FIELD_MAX) ? {FIELD_BITS{1'b1}} : FIELD_BITS'(w);
	endfunction

endpackage

// File: hdl/jpeg_header_scan_locator.sv
`timescale 1ns / 1ps

// JPEG header scan locator.
// Input channel: one image byte per beat (byte_in) with last_byte on the
// final byte. The parser walks SOI, optional APP0, DQT(s), SOF0, DHT(s)
// and SOS, skipping segment bodies and grabbing height/width from SOF0.
// Output channel: exactly one result beat per image, issued for the beat
// that carries last_byte: status, scan_offset, scan_length,
// frame_width, frame_height (all four zero unless status is ok).
// Throughput: one byte per cycle, except while a last byte waits behind
// a held result. The per-byte parse update is combinational logic
// between the input register and the state/result registers.
// Result path: the last beat lands in the input register when accepted
// and is parsed into the result register when it advances, which raises
// out_valid; a held result can keep it waiting in the input register.
// Stall: a held result (out_stall high) only blocks a further last byte;
// ordinary header/scan bytes keep flowing into the parser meanwhile.
// Reset (arst_n low, async) empties both registers and puts the parser at
// the start of an image; it also returns there after every result.
module jpeg_header_scan_locator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [23:0] scan_offset,
	output logic [23:0] scan_length,
	output logic [15:0] frame_width,
	output logic [15:0] frame_height
);
	import jhsl_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       out_valid_q;
	result_t    res_q;
	result_t    res_now;

	logic       out_free;
	logic       advance;
	logic       accept;

	// output slot is free if empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	// a byte without last_byte makes no result, so it never waits
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	jhsl_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.last_byte (last_s1),
		.result    (res_now)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= byte_in;
			last_s1 <= last_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res_now;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign scan_offset  = res_q.scan_offset;
	assign scan_length  = res_q.scan_length;
	assign frame_width  = res_q.frame_width;
	assign frame_height = res_q.frame_height;

endmodule

// File: hdl/jhsl_parser.sv
`timescale 1ns / 1ps

module jhsl_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic              last_byte,
	output jhsl_pkg::result_t result
);
	import jhsl_pkg::*;

	phase_t                phase_q, phase_d;
	kind_t                 kind_q, kind_d;
	status_t               error_q, error_d;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] found_q, found_d;
	logic [15:0]           remain_q, remain_d;
	logic [7:0]            len_high_q, len_high_d;
	logic                  seen_dqt_q, seen_dqt_d;
	logic                  seen_dht_q, seen_dht_d;
	logic [15:0]           width_q, width_d;
	logic [15:0]           height_q, height_d;
	logic [2:0]            sof_pos_q, sof_pos_d;

	logic [COUNT_BITS:0]   count_inc;
	logic [COUNT_BITS-1:0] count_sat;
	logic [15:0]           seg_len;
	logic [15:0]           remain_dec;
	logic                  mk_ok;
	kind_t                 mk_kind;
	logic                  seg_done;

	assign count_inc = {1'b0, count_q} + {{COUNT_BITS{1'b0}}, 1'b1};
	assign count_sat = count_inc[COUNT_BITS] ? {COUNT_BITS{1'b1}}
		: count_inc[COUNT_BITS-1:0];
	assign seg_len   = {len_high_q, byte_in};
	assign remain_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : remain_q;

	// marker legality against the previous segment kind
	always_comb begin
		mk_ok   = 1'b0;
		mk_kind = KIND_NONE;
		case (byte_in)
			MK_APP0: begin
				mk_ok   = (kind_q == KIND_NONE);
				mk_kind = KIND_APP0;
			end
			MK_DQT: begin
				mk_ok   = (kind_q == KIND_NONE) || (kind_q == KIND_APP0)
					|| (kind_q == KIND_DQT);
				mk_kind = KIND_DQT;
			end
			MK_SOF0: begin
				mk_ok   = (kind_q == KIND_DQT) && seen_dqt_q;
				mk_kind = KIND_SOF;
			end
			MK_DHT: begin
				mk_ok   = (kind_q == KIND_SOF) || (kind_q == KIND_DHT);
				mk_kind = KIND_DHT;
			end
			MK_SOS: begin
				mk_ok   = (kind_q == KIND_DHT) && seen_dht_q;
				mk_kind = KIND_SOS;
			end
			default: begin
				mk_ok   = 1'b0;
				mk_kind = KIND_NONE;
			end
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		error_d    = error_q;
		found_d    = found_q;
		remain_d   = remain_q;
		len_high_d = len_high_q;
		seen_dqt_d = seen_dqt_q;
		seen_dht_d = seen_dht_q;
		width_d    = width_q;
		height_d   = height_q;
		sof_pos_d  = sof_pos_q;
		seg_done   = 1'b0;

		unique case (phase_q)
			PH_SOI0: begin
				if (byte_in == MK_PREFIX) begin
					phase_d = PH_SOI1;
				end else begin
					phase_d = PH_HALT;
					error_d = ST_ORDER;
				end
			end
			PH_SOI1: begin
				if (byte_in == MK_SOI) begin
					phase_d = PH_MK0;
				end else begin
					phase_d = PH_HALT;
					error_d = ST_ORDER;
				end
			end
			PH_MK0: begin
				if (byte_in == MK_PREFIX) begin
					phase_d = PH_MK1;
				end else begin
					phase_d = PH_HALT;
					error_d = ST_ORDER;
				end
			end
			PH_MK1: begin
				if (mk_ok) begin
					kind_d    = mk_kind;
					sof_pos_d = 3'd0;
					phase_d   = PH_LENH;
					if (mk_kind == KIND_DQT) seen_dqt_d = 1'b1;
					if (mk_kind == KIND_DHT) seen_dht_d = 1'b1;
				end else begin
					phase_d = PH_HALT;
					error_d = ST_ORDER;
				end
			end
			PH_LENH: begin
				len_high_d = byte_in;
				phase_d    = PH_LENL;
			end
			PH_LENL: begin
				if (seg_len < 16'd2) begin
					phase_d = PH_HALT;
					error_d = ST_LEN;
				end else begin
					remain_d = seg_len - 16'd2;
					if (seg_len == 16'd2) seg_done = 1'b1;
					else phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				if (kind_q == KIND_SOF) begin
					case (sof_pos_q)
						3'd1:    height_d = {byte_in, height_q[7:0]};
						3'd2:    height_d = {height_q[15:8], byte_in};
						3'd3:    width_d  = {byte_in, width_q[7:0]};
						3'd4:    width_d  = {width_q[15:8], byte_in};
						default: ;
					endcase
					if (sof_pos_q != 3'd7) sof_pos_d = sof_pos_q + 3'd1;
				end
				remain_d = remain_dec;
				if (remain_dec == 16'd0) seg_done = 1'b1;
			end
			PH_SCAN, PH_HALT: ;
			default: ;
		endcase

		if (seg_done) begin
			if (kind_q == KIND_SOS) begin
				found_d = count_sat;
				phase_d = PH_SCAN;
			end else begin
				phase_d = PH_MK0;
			end
		end
	end

	// result from the state as it stands after this byte
	always_comb begin
		result = '0;
		if (error_d != ST_OK) begin
			result.status = error_d;
		end else if (phase_d == PH_SCAN) begin
			result.status       = ST_OK;
			result.scan_offset  = sat_field({1'b0, found_d});
			result.scan_length  = sat_field(count_inc - {1'b0, found_d});
			result.frame_width  = width_d;
			result.frame_height = height_d;
		end else begin
			result.status = ST_TRUNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SOI0;
			kind_q     <= KIND_NONE;
			error_q    <= ST_OK;
			count_q    <= '0;
			found_q    <= '0;
			remain_q   <= '0;
			len_high_q <= '0;
			seen_dqt_q <= 1'b0;
			seen_dht_q <= 1'b0;
			width_q    <= '0;
			height_q   <= '0;
			sof_pos_q  <= '0;
		end else if (step) begin
			if (last_byte) begin
				phase_q    <= PH_SOI0;
				kind_q     <= KIND_NONE;
				error_q    <= ST_OK;
				count_q    <= '0;
				found_q    <= '0;
				remain_q   <= '0;
				len_high_q <= '0;
				seen_dqt_q <= 1'b0;
				seen_dht_q <= 1'b0;
				width_q    <= '0;
				height_q   <= '0;
				sof_pos_q  <= '0;
			end else begin
				phase_q    <= phase_d;
				kind_q     <= kind_d;
				error_q    <= error_d;
				count_q    <= count_sat;
				found_q    <= found_d;
				remain_q   <= remain_d;
				len_high_q <= len_high_d;
				seen_dqt_q <= seen_dqt_d;
				seen_dht_q <= seen_dht_d;
				width_q    <= width_d;
				height_q   <= height_d;
				sof_pos_q  <= sof_pos_d;
			end
		end
	end

endmodule

// File: hdl/jhsl_checker.sv
`timescale 1ns / 1ps

module jhsl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [23:0] scan_offset,
	input logic [23:0] scan_length,
	input logic [15:0] frame_width,
	input logic [15:0] frame_height
);
	import jhsl_pkg::*;

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(scan_offset) && $stable(scan_length))
		else $error("result changed while stalled");

	// failed images report zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (scan_offset == 24'd0)
			&& (scan_length == 24'd0) && (frame_width == 16'd0)
			&& (frame_height == 16'd0))
		else $error("nonzero fields on error status");

	// shortest legal header is SOI plus four empty segments
	a_min_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |-> scan_offset >= 24'd18)
		else $error("scan offset inside minimal header");

	// input only backs up behind a pending result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind jpeg_header_scan_locator jhsl_checker u_checker (.*);

// File: tb/jpeg_header_scan_locator_tb.sv
`timescale 1ns / 1ps

module jpeg_header_scan_locator_tb;
	import jhsl_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  byte_in   = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [23:0] scan_offset;
	logic [23:0] scan_length;
	logic [15:0] frame_width;
	logic [15:0] frame_height;

	// idle odds in percent for each side; the receiver also honors a long hold
	int send_idle    = 0;
	int recv_idle    = 0;
	int hold_request = 0;

	int cycle_count = 0;
	int mismatches  = 0;
	int bytes_sent  = 0;
	int images_sent = 0;

	// reports predicted from accepted bytes, oldest first
	result_t expected_reports[$];

	// image under construction, with the positions of marker codes and lengths
	logic [7:0] img_bytes[$];
	int         mk_pos[$];
	int         len_pos[$];

	// shadow parser state
	phase_t               ps_phase;
	kind_t                ps_kind;
	status_t              ps_error;
	logic [COUNT_BITS-1:0] ps_count;
	logic [COUNT_BITS-1:0] ps_offset;
	logic [15:0]          ps_remaining;
	logic [7:0]           ps_len_hi;
	logic                 ps_seen_dqt;
	logic                 ps_seen_dht;
	logic [15:0]          ps_width;
	logic [15:0]          ps_height;
	int                   ps_sof_pos;

	jpeg_header_scan_locator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_in      (byte_in),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.scan_offset  (scan_offset),
		.scan_length  (scan_length),
		.frame_width  (frame_width),
		.frame_height (frame_height)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow parser: walks the same marker/segment grammar as the block
	// ------------------------------------------------------------------

	function automatic void clear_parser();
		ps_phase     = PH_SOI0;
		ps_kind      = KIND_NONE;
		ps_error     = ST_OK;
		ps_count     = '0;
		ps_offset    = '0;
		ps_remaining = '0;
		ps_len_hi    = '0;
		ps_seen_dqt  = 1'b0;
		ps_seen_dht  = 1'b0;
		ps_width     = '0;
		ps_height    = '0;
		ps_sof_pos   = 0;
	endfunction

	// byte counter only ever grows by one, so bit COUNT_BITS means overflow
	function automatic logic [COUNT_BITS-1:0] count_clamp(logic [COUNT_BITS:0] v);
		return v[COUNT_BITS] ? '1 : v[COUNT_BITS-1:0];
	endfunction

	function automatic logic [23:0] field_clamp(logic [COUNT_BITS:0] v);
		return (v > 'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
	endfunction

	// once halted, everything up to last_byte is ignored
	function automatic void halt(status_t code);
		ps_error = code;
		ps_phase = PH_HALT;
	endfunction

	// end of a segment body; SOS hands over to the scan data
	function automatic void close_segment(logic [COUNT_BITS:0] next_idx);
		if (ps_kind == KIND_SOS) begin
			ps_offset = count_clamp(next_idx);
			ps_phase  = PH_SCAN;
		end else begin
			ps_phase = PH_MK0;
		end
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic fin);
		logic [COUNT_BITS:0] next_idx;
		logic [15:0]         seg_len;
		logic                ok;
		kind_t               nk;
		result_t             rep;
		next_idx = {1'b0, ps_count} + 1'b1;
		case (ps_phase)
			PH_SOI0: if (b == MK_PREFIX) ps_phase = PH_SOI1; else halt(ST_ORDER);
			PH_SOI1: if (b == MK_SOI) ps_phase = PH_MK0; else halt(ST_ORDER);
			PH_MK0:  if (b == MK_PREFIX) ps_phase = PH_MK1; else halt(ST_ORDER);
			PH_MK1: begin
				// marker must follow the fixed order APP0? DQT+ SOF0 DHT+ SOS
				ok = 1'b0;
				nk = KIND_NONE;
				case (b)
					MK_APP0: begin
						ok = (ps_kind == KIND_NONE);
						nk = KIND_APP0;
					end
					MK_DQT: begin
						ok = (ps_kind inside {KIND_NONE, KIND_APP0, KIND_DQT});
						nk = KIND_DQT;
					end
					MK_SOF0: begin
						ok = (ps_kind == KIND_DQT) && ps_seen_dqt;
						nk = KIND_SOF;
					end
					MK_DHT: begin
						ok = (ps_kind inside {KIND_SOF, KIND_DHT});
						nk = KIND_DHT;
					end
					MK_SOS: begin
						ok = (ps_kind == KIND_DHT) && ps_seen_dht;
						nk = KIND_SOS;
					end
					default: ok = 1'b0;
				endcase
				if (!ok) begin
					halt(ST_ORDER);
				end else begin
					ps_kind = nk;
					if (nk == KIND_DQT) ps_seen_dqt = 1'b1;
					if (nk == KIND_DHT) ps_seen_dht = 1'b1;
					ps_sof_pos = 0;
					ps_phase   = PH_LENH;
				end
			end
			PH_LENH: begin
				ps_len_hi = b;
				ps_phase  = PH_LENL;
			end
			PH_LENL: begin
				seg_len = {ps_len_hi, b};
				if (seg_len < 16'd2) begin
					halt(ST_LEN);
				end else begin
					ps_remaining = seg_len - 16'd2;
					if (ps_remaining == 0) close_segment(next_idx);
					else ps_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				// SOF0 body: precision, height hi/lo, width hi/lo, ...
				if (ps_kind == KIND_SOF) begin
					case (ps_sof_pos)
						1: ps_height[15:8] = b;
						2: ps_height[7:0]  = b;
						3: ps_width[15:8]  = b;
						4: ps_width[7:0]   = b;
						default: ;
					endcase
					if (ps_sof_pos < 7) ps_sof_pos++;
				end
				if (ps_remaining != 0) ps_remaining--;
				if (ps_remaining == 0) close_segment(next_idx);
			end
			default: ;
		endcase
		ps_count = count_clamp(next_idx);

		if (fin) begin
			rep = '0;
			if (ps_error != ST_OK) begin
				rep.status = ps_error;
			end else if (ps_phase == PH_SCAN) begin
				rep.status       = ST_OK;
				rep.scan_offset  = field_clamp({1'b0, ps_offset});
				rep.scan_length  = (next_idx >= {1'b0, ps_offset}) ?
					field_clamp(next_idx - {1'b0, ps_offset}) : 24'd0;
				rep.frame_width  = ps_width;
				rep.frame_height = ps_height;
			end else begin
				rep.status = ST_TRUNC;
			end
			expected_reports.push_back(rep);
			clear_parser();
		end
	endfunction

	initial clear_parser();

	// ------------------------------------------------------------------
	// Monitors: both channels sampled at the edge, before any update lands
	// ------------------------------------------------------------------

	task automatic check_report();
		result_t want;
		if (expected_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected report beat: st=%0d off=%0d len=%0d w=%0d h=%0d",
					$realtime, status, scan_offset, scan_length, frame_width,
					frame_height);
			return;
		end
		want = expected_reports.pop_front();
		if (status !== want.status || scan_offset !== want.scan_offset ||
				scan_length !== want.scan_length ||
				frame_width !== want.frame_width || frame_height !== want.frame_height) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: report mismatch: exp st=%0d off=%0d len=%0d w=%0d h=%0d",
					$realtime, want.status, want.scan_offset, want.scan_length,
					want.frame_width, want.frame_height);
				$display("%0t:                  got st=%0d off=%0d len=%0d w=%0d h=%0d",
					$realtime, status, scan_offset, scan_length, frame_width,
					frame_height);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) check_report();
		if (arst_n && in_valid && !in_stall) parse_byte(byte_in, last_byte);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: random stall, or a long hold when a test asks for one
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// one beat; valid stays up on return so back-to-back beats need no gap
	task automatic send_byte(logic [7:0] b, logic fin);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		byte_in   <= b;
		last_byte <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_image();
		foreach (img_bytes[i]) send_byte(img_bytes[i], i == img_bytes.size() - 1);
		bytes_sent += img_bytes.size();
		images_sent++;
	endtask

	// drop valid so that an idle stretch never repeats the last beat
	task automatic park_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void push_segment(logic [7:0] code, int body);
		logic [15:0] seg_len;
		seg_len = 16'(body + 2);
		img_bytes.push_back(MK_PREFIX);
		mk_pos.push_back(img_bytes.size());
		img_bytes.push_back(code);
		len_pos.push_back(img_bytes.size());
		img_bytes.push_back(seg_len[15:8]);
		img_bytes.push_back(seg_len[7:0]);
		repeat (body) img_bytes.push_back(8'($urandom));
	endfunction

	// mostly tiny bodies; now and then one past 255 to exercise the high length byte
	function automatic int body_size();
		return ($urandom_range(24) == 0) ? 256 + int'($urandom_range(6)) :
			int'($urandom_range(6));
	endfunction

	function automatic void build_clean_image();
		img_bytes.delete();
		mk_pos.delete();
		len_pos.delete();
		img_bytes.push_back(MK_PREFIX);
		img_bytes.push_back(MK_SOI);
		if ($urandom_range(1)) push_segment(MK_APP0, body_size());
		repeat ($urandom_range(2, 1)) push_segment(MK_DQT, body_size());
		// short SOF now and then, so width/height are only partly reached
		push_segment(MK_SOF0, ($urandom_range(3) == 0) ? int'($urandom_range(4)) :
			int'($urandom_range(9, 5)));
		repeat ($urandom_range(2, 1)) push_segment(MK_DHT, body_size());
		push_segment(MK_SOS, $urandom_range(4));
		// a quarter of the images end right on the SOS segment
		if ($urandom_range(3) != 0)
			repeat ($urandom_range(12, 1)) img_bytes.push_back(8'($urandom));
	endfunction

	function automatic void build_image();
		int         pick;
		int         p;
		logic [7:0] code;
		pick = $urandom_range(99);
		if (pick >= 95) begin
			// plain noise, sometimes starting like a marker
			img_bytes.delete();
			repeat ($urandom_range(8, 1)) img_bytes.push_back(8'($urandom));
			if ($urandom_range(1)) img_bytes[0] = MK_PREFIX;
			return;
		end
		build_clean_image();
		if (pick >= 90) begin
			// swap a marker code: out of order, repeated, missing table or unknown
			case ($urandom_range(5))
				0: code = MK_APP0;
				1: code = MK_DQT;
				2: code = MK_SOF0;
				3: code = MK_DHT;
				4: code = MK_SOS;
				default: code = 8'($urandom);
			endcase
			img_bytes[mk_pos[$urandom_range(mk_pos.size() - 1)]] = code;
		end else if (pick >= 85) begin
			// segment length of 0 or 1
			p = len_pos[$urandom_range(len_pos.size() - 1)];
			img_bytes[p]     = 8'h00;
			img_bytes[p + 1] = 8'($urandom_range(1));
		end else if (pick >= 75) begin
			img_bytes[$urandom_range(img_bytes.size() - 1)] = 8'($urandom);
		end else if (pick >= 65) begin
			// stream cut short somewhere in the headers or scan
			p = $urandom_range(img_bytes.size() - 1, 1);
			while (img_bytes.size() > p) void'(img_bytes.pop_back());
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// hand-built images: bad first byte, cut after a prefix, length of one,
	// and a minimal valid image that ends right on SOS with extreme sizes
	task automatic test_directed();
		send_idle = 18;
		recv_idle = 55;

		img_bytes = '{8'h00};
		send_image();

		img_bytes = '{MK_PREFIX};
		send_image();

		img_bytes = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_DQT, 8'h00, 8'h01};
		send_image();

		img_bytes = '{MK_PREFIX, MK_SOI,
			MK_PREFIX, MK_DQT, 8'h00, 8'h02,
			MK_PREFIX, MK_SOF0, 8'h00, 8'h07, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h00,
			MK_PREFIX, MK_DHT, 8'h00, 8'h02,
			MK_PREFIX, MK_SOS, 8'h00, 8'h02};
		send_image();

		park_input();
	endtask

	task automatic test_random_stream(int s_idle, int r_idle, int min_bytes,
			int min_images);
		int b0;
		int i0;
		send_idle = s_idle;
		recv_idle = r_idle;
		b0 = bytes_sent;
		i0 = images_sent;
		while (bytes_sent - b0 < min_bytes || images_sent - i0 < min_images) begin
			build_image();
			send_image();
		end
		park_input();
	endtask

	// receiver holds off while short images keep coming, so a second
	// last byte has to back up behind the held report
	task automatic test_backpressure();
		send_idle    = 0;
		recv_idle    = 0;
		hold_request = HOLD_CYCLES;
		for (int k = 0; k < 12; k++) begin
			if (k % 2) begin
				build_clean_image();
			end else begin
				img_bytes.delete();
				repeat ($urandom_range(3, 1)) img_bytes.push_back(8'($urandom));
			end
			send_image();
		end
		park_input();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_stream(18, 55, 240, 3);
		test_random_stream(55, 18, 240, 3);
		test_backpressure();
		test_random_stream(0, 0, 240, 3);

		// drain, then give the block time to show any stray beat
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/jhsl_pkg.sv
hdl/jhsl_parser.sv
hdl/jpeg_header_scan_locator.sv
hdl/jhsl_checker.sv
tb/jpeg_header_scan_locator_tb.sv
